### hdl/lzwd_pkg.sv
// Package for the LZW stream decoder: sizes, control codes, status codes and the
// dictionary and staging write-port types. No dependencies.
`timescale 1ns / 1ps
package lzwd_pkg;

    localparam int CODE_BITS  = 12;
    localparam int NF_BITS    = 13;
    localparam int LEN_BITS   = 13;
    localparam int POS_BITS   = 14;
    localparam int ACC_BITS   = 20;
    localparam int HELD_BITS  = 5;
    localparam int WIDTH_BITS = 4;
    localparam int BUF_DEPTH  = 4096;
    localparam int RESULT_LIMIT = 61;
    localparam int OUT_BYTES  = 64;
    localparam int MIN_WIDTH  = 9;

    localparam int DEF_TABLE_DEPTH    = 4096;
    localparam int DEF_MAX_CODE_WIDTH = 12;
    localparam int DEF_CHUNK_BYTES    = 64;

    localparam logic [CODE_BITS-1:0] CODE_CLEAR = 12'd256;
    localparam logic [CODE_BITS-1:0] CODE_EOD   = 12'd257;
    localparam logic [NF_BITS-1:0]   FIRST_FREE = 13'd258;

    localparam logic [1:0] ST_RUN  = 2'd0;
    localparam logic [1:0] ST_DONE = 2'd1;
    localparam logic [1:0] ST_ERR  = 2'd2;

    typedef struct packed {
        logic [LEN_BITS-1:0]  len;
        logic [CODE_BITS-1:0] head;
        logic [7:0]           tail;
    } dict_entry_t;

    typedef struct packed {
        logic                 en;
        logic [CODE_BITS-1:0] addr;
        dict_entry_t          data;
    } dict_wr_t;

    typedef struct packed {
        logic                en;
        logic [POS_BITS-1:0] addr;
        logic [7:0]          data;
    } stage_wr_t;

endpackage

### hdl/lzwd_dict_ram.sv
// Dictionary memory: one write port, one registered read port.
// Depends on lzwd_pkg for the entry and write-port types.
`timescale 1ns / 1ps
module lzwd_dict_ram #(
    parameter int DEPTH = lzwd_pkg::DEF_TABLE_DEPTH
) (
    input  logic                                  aclk,
    input  lzwd_pkg::dict_wr_t                    wr,
    input  logic                                  rd_en,
    input  logic [lzwd_pkg::CODE_BITS-1:0]        rd_addr,
    output lzwd_pkg::dict_entry_t                 rd_data
);
    import lzwd_pkg::*;

    localparam int AW = $clog2(DEPTH);

    dict_entry_t mem [DEPTH];
    dict_entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr[AW-1:0]] <= wr.data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr[AW-1:0]];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hdl/lzwd_stage_ram.sv
// Staging memory for the decoded bytes of one input word, registered read.
// Depends on lzwd_pkg for the write-port type.
`timescale 1ns / 1ps
module lzwd_stage_ram #(
    parameter int DEPTH = lzwd_pkg::RESULT_LIMIT * lzwd_pkg::DEF_CHUNK_BYTES
) (
    input  logic                                 aclk,
    input  lzwd_pkg::stage_wr_t                  wr,
    input  logic                                 rd_en,
    input  logic [lzwd_pkg::POS_BITS-1:0]        rd_addr,
    output logic [7:0]                           rd_data
);
    import lzwd_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr[AW-1:0]] <= wr.data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr[AW-1:0]];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hdl/lzw_stream_decoder_unit.sv
// LZW stream decoder top level: bit unpacker, code sequencer, chain walker and chunker.
// Depends on lzwd_pkg, lzwd_dict_ram and lzwd_stage_ram.
//
// channel | dir | handshake         | payload
// s_      | in  | s_valid/s_ready   | s_in_byte, s_end_of_input
// m_      | out | m_valid/m_ready   | m_chunk_word0..7, m_byte_count, m_last_chunk, m_status
// cfg_    | in  | cfg_wr_en         | cfg_wr_data (early_change)
//
// Steps: per input word accept, extract codes, output start; per code a check, a walk over the
// string and a commit, with a dictionary lookup first for a table code, and only the check for
// a clear; per chunk an init, a fill of its bytes and the wait for m_ready.
// Reset: aresetn synchronous, active low; dictionary and staging memory are not cleared.
// s_ready is high only between words; a held chunk stalls the block until taken.
`timescale 1ns / 1ps
module lzw_stream_decoder_unit #(
    parameter int TABLE_DEPTH    = lzwd_pkg::DEF_TABLE_DEPTH,
    parameter int MAX_CODE_WIDTH = lzwd_pkg::DEF_MAX_CODE_WIDTH,
    parameter int CHUNK_BYTES    = lzwd_pkg::DEF_CHUNK_BYTES
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_byte,
    input  logic        s_end_of_input,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_chunk_word0,
    output logic [63:0] m_chunk_word1,
    output logic [63:0] m_chunk_word2,
    output logic [63:0] m_chunk_word3,
    output logic [63:0] m_chunk_word4,
    output logic [63:0] m_chunk_word5,
    output logic [63:0] m_chunk_word6,
    output logic [63:0] m_chunk_word7,
    output logic [6:0]  m_byte_count,
    output logic        m_last_chunk,
    output logic [1:0]  m_status
);
    import lzwd_pkg::*;

    localparam int STAGE_DEPTH = RESULT_LIMIT * CHUNK_BYTES;
    localparam int CNT_W       = $clog2(STAGE_DEPTH + 1);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_EXTRACT = 4'd1;
    localparam logic [3:0] S_CHECK   = 4'd2;
    localparam logic [3:0] S_LOOKUP  = 4'd3;
    localparam logic [3:0] S_WALK    = 4'd4;
    localparam logic [3:0] S_COMMIT  = 4'd5;
    localparam logic [3:0] S_OUTSTRT = 4'd6;
    localparam logic [3:0] S_CHKINIT = 4'd7;
    localparam logic [3:0] S_FILL    = 4'd8;
    localparam logic [3:0] S_HOLD    = 4'd9;

    localparam logic [NF_BITS-1:0]  NF_FULL   = NF_BITS'(TABLE_DEPTH + 1);
    localparam logic [NF_BITS-1:0]  NF_DEPTH  = NF_BITS'(TABLE_DEPTH);
    localparam logic [LEN_BITS-1:0] LEN_MAX   = LEN_BITS'(BUF_DEPTH);
    localparam logic [POS_BITS-1:0] POS_LIMIT = POS_BITS'(STAGE_DEPTH);
    localparam logic [CNT_W-1:0]    CNT_LIMIT = CNT_W'(STAGE_DEPTH);
    localparam logic [CNT_W-1:0]    CNT_CHUNK = CNT_W'(CHUNK_BYTES);
    localparam logic [WIDTH_BITS-1:0] W_MAX   = WIDTH_BITS'(MAX_CODE_WIDTH);
    localparam logic [WIDTH_BITS-1:0] W_MIN   = WIDTH_BITS'(MIN_WIDTH);

    logic [3:0]             state_reg, state_next;
    logic [ACC_BITS-1:0]    acc_reg, acc_next;
    logic [HELD_BITS-1:0]   held_reg, held_next;
    logic [NF_BITS-1:0]     nf_reg, nf_next;
    logic [WIDTH_BITS-1:0]  width_reg, width_next;
    logic [CODE_BITS-1:0]   prev_code_reg, prev_code_next;
    logic                   fac_reg, fac_next;
    logic [LEN_BITS-1:0]    prev_len_reg, prev_len_next;
    logic [7:0]             prev_first_reg, prev_first_next;
    logic                   over_reg, over_next;
    logic                   early_reg, early_next;
    logic                   eoi_reg, eoi_next;
    logic                   got_reg, got_next;
    logic [1:0]             status_reg, status_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [CODE_BITS-1:0]   code_reg, code_next;
    logic [CODE_BITS-1:0]   j_reg, j_next;
    logic [LEN_BITS-1:0]    r_reg, r_next;
    logic [POS_BITS-1:0]    pos_reg, pos_next;
    logic [LEN_BITS-1:0]    len_reg, len_next;
    logic [7:0]             first_reg, first_next;
    logic [CNT_W-1:0]       base_reg, base_next;
    logic [6:0]             n_reg, n_next;
    logic                   last_reg, last_next;
    logic [6:0]             issue_reg, issue_next;
    logic                   pend_reg, pend_next;
    logic [5:0]             pend_idx_reg, pend_idx_next;
    logic [OUT_BYTES*8-1:0] chunk_reg, chunk_next;

    dict_wr_t               dict_wr;
    logic                   dict_rd_en;
    logic [CODE_BITS-1:0]   dict_rd_addr;
    dict_entry_t            dict_rd;
    stage_wr_t              st_wr;
    logic                   st_rd_en;
    logic [POS_BITS-1:0]    st_rd_addr;
    logic [7:0]             st_rd;

    logic [HELD_BITS-1:0]   shift_amt;
    logic [ACC_BITS-1:0]    acc_shifted;
    logic [CODE_BITS-1:0]   code_ext;
    logic [POS_BITS-1:0]    count_pos;
    logic [POS_BITS-1:0]    sum_pos;
    logic [NF_BITS-1:0]     nf_inc;
    logic [CNT_W-1:0]       rem;

    lzwd_dict_ram #(.DEPTH(TABLE_DEPTH)) u_dict (
        .aclk    (aclk),
        .wr      (dict_wr),
        .rd_en   (dict_rd_en),
        .rd_addr (dict_rd_addr),
        .rd_data (dict_rd)
    );

    lzwd_stage_ram #(.DEPTH(STAGE_DEPTH)) u_stage (
        .aclk    (aclk),
        .wr      (st_wr),
        .rd_en   (st_rd_en),
        .rd_addr (st_rd_addr),
        .rd_data (st_rd)
    );

    assign shift_amt   = held_reg - HELD_BITS'(width_reg);
    assign acc_shifted = acc_reg >> shift_amt;
    assign code_ext    = acc_shifted[CODE_BITS-1:0] & (12'hFFF >> (4'd12 - width_reg));
    assign count_pos   = POS_BITS'(count_reg);
    assign sum_pos     = count_pos + POS_BITS'(len_reg);
    assign nf_inc      = nf_reg + 13'd1;
    assign rem         = count_reg - base_reg;

    always_comb begin
        state_next      = state_reg;
        acc_next        = acc_reg;
        held_next       = held_reg;
        nf_next         = nf_reg;
        width_next      = width_reg;
        prev_code_next  = prev_code_reg;
        fac_next        = fac_reg;
        prev_len_next   = prev_len_reg;
        prev_first_next = prev_first_reg;
        over_next       = over_reg;
        early_next      = cfg_wr_en ? cfg_wr_data : early_reg;
        eoi_next        = eoi_reg;
        got_next        = got_reg;
        status_next     = status_reg;
        count_next      = count_reg;
        code_next       = code_reg;
        j_next          = j_reg;
        r_next          = r_reg;
        pos_next        = pos_reg;
        len_next        = len_reg;
        first_next      = first_reg;
        base_next       = base_reg;
        n_next          = n_reg;
        last_next       = last_reg;
        issue_next      = issue_reg;
        pend_next       = 1'b0;
        pend_idx_next   = pend_idx_reg;
        chunk_next      = chunk_reg;
        dict_wr         = '0;
        dict_rd_en      = 1'b0;
        dict_rd_addr    = code_reg;
        st_wr           = '0;
        st_rd_en        = 1'b0;
        st_rd_addr      = POS_BITS'(base_reg) + POS_BITS'(issue_reg);

        case (state_reg)
            S_IDLE: begin
                if (s_valid && !over_reg) begin
                    acc_next    = {acc_reg[ACC_BITS-9:0], s_in_byte};
                    held_next   = held_reg + 5'd8;
                    eoi_next    = s_end_of_input;
                    got_next    = 1'b0;
                    status_next = ST_RUN;
                    count_next  = '0;
                    state_next  = S_EXTRACT;
                end
            end
            S_EXTRACT: begin
                if (held_reg >= HELD_BITS'(width_reg)) begin
                    code_next  = code_ext;
                    held_next  = shift_amt;
                    got_next   = 1'b1;
                    state_next = S_CHECK;
                end else begin
                    if (eoi_reg) begin
                        status_next = got_reg ? ST_DONE : ST_ERR;
                        over_next   = 1'b1;
                    end
                    state_next = S_OUTSTRT;
                end
            end
            S_CHECK: begin
                if (code_reg == CODE_EOD) begin
                    status_next = ST_DONE;
                    over_next   = 1'b1;
                    state_next  = S_OUTSTRT;
                end else if (code_reg == CODE_CLEAR) begin
                    nf_next       = FIRST_FREE;
                    width_next    = W_MIN;
                    prev_len_next = '0;
                    fac_next      = 1'b1;
                    state_next    = S_EXTRACT;
                end else if (nf_reg >= NF_FULL ||
                             (fac_reg && NF_BITS'(code_reg) >= FIRST_FREE)) begin
                    status_next = ST_ERR;
                    over_next   = 1'b1;
                    count_next  = '0;
                    state_next  = S_OUTSTRT;
                end else if (code_reg < 12'd256) begin
                    // literal: single-step walk that only writes the root byte
                    j_next     = code_reg;
                    r_next     = '0;
                    pos_next   = count_pos;
                    len_next   = 13'd1;
                    state_next = S_WALK;
                end else if (NF_BITS'(code_reg) < nf_reg) begin
                    if (NF_BITS'(code_reg) >= NF_DEPTH) begin
                        status_next = ST_ERR;
                        over_next   = 1'b1;
                        count_next  = '0;
                        state_next  = S_OUTSTRT;
                    end else begin
                        dict_rd_en   = 1'b1;
                        dict_rd_addr = code_reg;
                        j_next       = code_reg;
                        state_next   = S_LOOKUP;
                    end
                end else if (NF_BITS'(code_reg) == nf_reg) begin
                    if (prev_len_reg >= LEN_MAX) begin
                        status_next = ST_ERR;
                        over_next   = 1'b1;
                        count_next  = '0;
                        state_next  = S_OUTSTRT;
                    end else begin
                        // KwKwK: previous string, then its own first byte at the end
                        st_wr.en     = (count_pos + POS_BITS'(prev_len_reg)) < POS_LIMIT;
                        st_wr.addr   = count_pos + POS_BITS'(prev_len_reg);
                        st_wr.data   = prev_first_reg;
                        dict_rd_en   = 1'b1;
                        dict_rd_addr = prev_code_reg;
                        j_next       = prev_code_reg;
                        r_next       = prev_len_reg - 13'd1;
                        pos_next     = count_pos + POS_BITS'(prev_len_reg) - 14'd1;
                        len_next     = prev_len_reg + 13'd1;
                        state_next   = S_WALK;
                    end
                end else begin
                    status_next = ST_ERR;
                    over_next   = 1'b1;
                    count_next  = '0;
                    state_next  = S_OUTSTRT;
                end
            end
            S_LOOKUP: begin
                if (dict_rd.len == '0 || dict_rd.len > LEN_MAX) begin
                    status_next = ST_ERR;
                    over_next   = 1'b1;
                    count_next  = '0;
                    state_next  = S_OUTSTRT;
                end else begin
                    r_next     = dict_rd.len - 13'd1;
                    pos_next   = count_pos + POS_BITS'(dict_rd.len) - 14'd1;
                    len_next   = dict_rd.len;
                    state_next = S_WALK;
                end
            end
            S_WALK: begin
                st_wr.en   = pos_reg < POS_LIMIT;
                st_wr.addr = pos_reg;
                if (r_reg != '0) begin
                    // write tail back to front, follow head
                    st_wr.data   = dict_rd.tail;
                    dict_rd_en   = 1'b1;
                    dict_rd_addr = dict_rd.head;
                    j_next       = dict_rd.head;
                    r_next       = r_reg - 13'd1;
                    pos_next     = pos_reg - 14'd1;
                end else begin
                    st_wr.data = j_reg[7:0];
                    first_next = j_reg[7:0];
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT: begin
                if (fac_reg) begin
                    fac_next = 1'b0;
                end else begin
                    dict_wr.en        = nf_reg < NF_DEPTH;
                    dict_wr.addr      = nf_reg[CODE_BITS-1:0];
                    dict_wr.data.len  = prev_len_reg + 13'd1;
                    dict_wr.data.head = prev_code_reg;
                    dict_wr.data.tail = first_reg;
                    nf_next           = nf_inc;
                    if (width_reg < W_MAX &&
                        ({1'b0, nf_inc} + {13'd0, early_reg}) == (14'd1 << width_reg)) begin
                        width_next = width_reg + 4'd1;
                    end
                end
                prev_code_next  = code_reg;
                prev_len_next   = len_reg;
                prev_first_next = first_reg;
                count_next      = (sum_pos > POS_LIMIT) ? CNT_LIMIT : sum_pos[CNT_W-1:0];
                state_next      = S_EXTRACT;
            end
            S_OUTSTRT: begin
                if (count_reg == '0) begin
                    if (status_reg != ST_RUN) begin
                        chunk_next = '0;
                        n_next     = '0;
                        last_next  = 1'b1;
                        state_next = S_HOLD;
                    end else begin
                        state_next = S_IDLE;
                    end
                end else begin
                    base_next  = '0;
                    state_next = S_CHKINIT;
                end
            end
            S_CHKINIT: begin
                chunk_next = '0;
                issue_next = '0;
                if (rem > CNT_CHUNK) begin
                    n_next    = 7'(CHUNK_BYTES);
                    last_next = 1'b0;
                end else begin
                    n_next    = rem[6:0];
                    last_next = 1'b1;
                end
                state_next = S_FILL;
            end
            S_FILL: begin
                if (issue_reg < n_reg) begin
                    st_rd_en      = 1'b1;
                    issue_next    = issue_reg + 7'd1;
                    pend_next     = 1'b1;
                    pend_idx_next = issue_reg[5:0];
                end
                if (pend_reg) begin
                    chunk_next[{pend_idx_reg, 3'b000} +: 8] = st_rd;
                end
                if (issue_reg == n_reg && !pend_reg) begin
                    state_next = S_HOLD;
                end
            end
            S_HOLD: begin
                if (m_ready) begin
                    if (last_reg) begin
                        state_next = S_IDLE;
                    end else begin
                        base_next  = base_reg + CNT_CHUNK;
                        state_next = S_CHKINIT;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            acc_reg        <= '0;
            held_reg       <= '0;
            nf_reg         <= FIRST_FREE;
            width_reg      <= W_MIN;
            prev_code_reg  <= '0;
            fac_reg        <= 1'b1;
            prev_len_reg   <= '0;
            prev_first_reg <= '0;
            over_reg       <= 1'b0;
            early_reg      <= 1'b1;
            eoi_reg        <= 1'b0;
            got_reg        <= 1'b0;
            status_reg     <= ST_RUN;
            count_reg      <= '0;
            r_reg          <= '0;
            base_reg       <= '0;
            n_reg          <= '0;
            last_reg       <= 1'b0;
            issue_reg      <= '0;
            pend_reg       <= 1'b0;
        end else begin
            state_reg      <= state_next;
            acc_reg        <= acc_next;
            held_reg       <= held_next;
            nf_reg         <= nf_next;
            width_reg      <= width_next;
            prev_code_reg  <= prev_code_next;
            fac_reg        <= fac_next;
            prev_len_reg   <= prev_len_next;
            prev_first_reg <= prev_first_next;
            over_reg       <= over_next;
            early_reg      <= early_next;
            eoi_reg        <= eoi_next;
            got_reg        <= got_next;
            status_reg     <= status_next;
            count_reg      <= count_next;
            r_reg          <= r_next;
            base_reg       <= base_next;
            n_reg          <= n_next;
            last_reg       <= last_next;
            issue_reg      <= issue_next;
            pend_reg       <= pend_next;
        end
        code_reg     <= code_next;
        j_reg        <= j_next;
        pos_reg      <= pos_next;
        len_reg      <= len_next;
        first_reg    <= first_next;
        pend_idx_reg <= pend_idx_next;
        chunk_reg    <= chunk_next;
    end

    assign s_ready       = (state_reg == S_IDLE);
    assign m_valid       = (state_reg == S_HOLD);
    assign m_chunk_word0 = chunk_reg[63:0];
    assign m_chunk_word1 = chunk_reg[127:64];
    assign m_chunk_word2 = chunk_reg[191:128];
    assign m_chunk_word3 = chunk_reg[255:192];
    assign m_chunk_word4 = chunk_reg[319:256];
    assign m_chunk_word5 = chunk_reg[383:320];
    assign m_chunk_word6 = chunk_reg[447:384];
    assign m_chunk_word7 = chunk_reg[511:448];
    assign m_byte_count  = n_reg;
    assign m_last_chunk  = last_reg;
    assign m_status      = last_reg ? status_reg : ST_RUN;

    a_idle_no_word: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !m_valid)
        else $error("input ready while a word is held");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_byte_count <= 7'(CHUNK_BYTES)))
        else $error("chunk byte count over chunk size");

    a_width_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (width_reg >= W_MIN) && (width_reg <= W_MAX))
        else $error("code width out of range");

    a_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != ST_RUN) |-> m_last_chunk)
        else $error("final status on a non-final chunk");

    a_error_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == ST_ERR) |-> (m_byte_count == 7'd0))
        else $error("bytes returned with error status");

endmodule

### test/lzw_stream_decoder_unit_tb.sv
// Testbench for lzw_stream_decoder_unit: packs generated LZW code streams into bytes,
// predicts the decoded chunks and checks each one. Depends on lzwd_pkg and the RTL.
`timescale 1ns / 1ps
module lzw_stream_decoder_unit_tb;
    import lzwd_pkg::*;

    typedef struct {
        bit [511:0] data;
        bit [6:0]   n;
        bit         last;
        bit [1:0]   st;
    } chunk_t;

    class lzw_scoreboard;
        bit        early;
        bit [19:0] acc;
        int        held, nf, cw, prev_code, prev_len, errors, chunks_seen, words_seen;
        bit        first, over;
        bit [7:0]  prev_first;
        bit [12:0] d_len[4096];
        bit [11:0] d_head[4096];
        bit [7:0]  d_tail[4096];
        bit [7:0]  sbuf[4096];
        bit [7:0]  staged[$];
        chunk_t    chunks_due[$];

        function new();
            early = 1; acc = 0; held = 0; nf = 258; cw = 9; prev_code = 0;
            prev_len = 0; first = 1; over = 0; prev_first = 0;
            errors = 0; chunks_seen = 0; words_seen = 0;
            foreach (d_len[i]) begin
                d_len[i] = 0; d_head[i] = 0; d_tail[i] = 0; sbuf[i] = 0;
            end
        endfunction

        // decode one code; returns running, done or error status
        function int run_code(int code);
            int len, i, j;
            if (code == CODE_EOD) return ST_DONE;
            if (code == CODE_CLEAR) begin
                nf = 258; cw = 9; prev_len = 0; first = 1;
                return ST_RUN;
            end
            if (nf >= 4097) return ST_ERR;
            if (first && code >= 258) return ST_ERR;
            if (code < 256) begin
                sbuf[0] = code[7:0];
                len = 1;
            end else if (code < nf) begin
                if (code >= 4096) return ST_ERR;
                len = d_len[code];
                if (len == 0 || len > 4096) return ST_ERR;
                j = code;
                for (i = len - 1; i > 0; i--) begin
                    if (j >= 4096) return ST_ERR;
                    sbuf[i] = d_tail[j];
                    j = d_head[j];
                end
                sbuf[0] = j[7:0];
            end else if (code == nf) begin
                if (prev_len >= 4096) return ST_ERR;
                sbuf[prev_len] = prev_first;
                len = prev_len + 1;
            end else begin
                return ST_ERR;
            end
            if (first) begin
                first = 0;
            end else begin
                if (nf < 4096) begin
                    d_len[nf]  = (prev_len + 1) & 13'h1fff;
                    d_head[nf] = prev_code[11:0];
                    d_tail[nf] = sbuf[0];
                end
                nf = (nf + 1) & 32'h1fff;
                if (cw < 12 && nf + early == (1 << cw)) cw++;
            end
            prev_code = code & 32'hfff;
            prev_len = len;
            prev_first = sbuf[0];
            for (i = 0; i < len; i++)
                if (staged.size() < RESULT_LIMIT * OUT_BYTES) staged.push_back(sbuf[i]);
            return ST_RUN;
        endfunction

        function void note_word(bit [7:0] b, bit eoi);
            int status, code, a, r, nres, base, cnt, k, i;
            bit got;
            chunk_t c;
            if (over) return;
            words_seen++;
            status = ST_RUN; got = 0;
            staged.delete();
            acc = {acc[11:0], b};
            held += 8;
            while (held >= cw && held <= 20) begin
                a = acc;
                code = (a >> (held - cw)) & ((1 << cw) - 1);
                held -= cw;
                got = 1;
                r = run_code(code);
                if (r != ST_RUN) begin
                    status = r; over = 1;
                    if (r == ST_ERR) staged.delete();
                    break;
                end
            end
            if (status == ST_RUN && eoi) begin
                status = got ? ST_DONE : ST_ERR;
                over = 1;
            end
            nres = (staged.size() + OUT_BYTES - 1) / OUT_BYTES;
            if (nres == 0 && status != ST_RUN) nres = 1;
            for (k = 0; k < nres; k++) begin
                base = k * OUT_BYTES;
                cnt = staged.size() - base;
                if (cnt < 0) cnt = 0;
                if (cnt > OUT_BYTES) cnt = OUT_BYTES;
                c.data = '0;
                for (i = 0; i < cnt; i++) c.data[8*i +: 8] = staged[base + i];
                c.n = 7'(cnt);
                c.last = (k + 1 == nres);
                c.st = c.last ? status[1:0] : ST_RUN;
                chunks_due.push_back(c);
            end
        endfunction

        function void check_chunk(chunk_t got);
            chunk_t want;
            chunks_seen++;
            if (chunks_due.size() == 0) begin
                $display("%0t: chunk with nothing expected (count %0d status %0d)",
                         $time, got.n, got.st);
                errors++;
                return;
            end
            want = chunks_due.pop_front();
            for (int k = 0; k < 8; k++)
                if (want.data[64*k +: 64] !== got.data[64*k +: 64]) begin
                    $display("%0t: chunk_word%0d expected %h got %h", $time, k,
                             want.data[64*k +: 64], got.data[64*k +: 64]);
                    errors++;
                end
            if (want.n !== got.n) begin
                $display("%0t: byte_count expected %0d got %0d", $time, want.n, got.n);
                errors++;
            end
            if (want.last !== got.last) begin
                $display("%0t: last_chunk expected %0d got %0d", $time, want.last, got.last);
                errors++;
            end
            if (want.st !== got.st) begin
                $display("%0t: status expected %0d got %0d", $time, want.st, got.st);
                errors++;
            end
        endfunction
    endclass

    typedef enum {END_EOD, END_BAD_CODE, END_FIRST_TABLE, END_TRUNC, END_FLAG_OK} finish_kind_t;

    logic        aclk = 0, aresetn = 0;
    logic        cfg_wr_en = 0, cfg_wr_data = 0;
    logic        s_valid = 0, s_end_of_input = 0, m_ready = 0;
    logic [7:0]  s_in_byte = 0;
    logic        s_ready, m_valid, m_last_chunk;
    logic [63:0] m_chunk_word0, m_chunk_word1, m_chunk_word2, m_chunk_word3;
    logic [63:0] m_chunk_word4, m_chunk_word5, m_chunk_word6, m_chunk_word7;
    logic [6:0]  m_byte_count;
    logic [1:0]  m_status;

    lzw_stream_decoder_unit dut (.*);

    lzw_scoreboard sb = new();
    bit   calm = 0, hold_long = 0;
    int   quiet_cycles = 0;
    int   max_width = 9;
    // encoder-side view of the decoder, used to pick legal codes and widths
    int   enc_nf = 258, enc_w = 9, enc_n = 0;
    bit   enc_first = 1, enc_early = 1;
    bit [31:0] enc_bits = 0;
    finish_kind_t ending;

    initial forever #5 aclk = ~aclk;

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= 40000) begin
            $display("watchdog: no handshake for %0d cycles", quiet_cycles);
            $display("lzw_stream_decoder_unit_tb: done, errors");
            $finish;
        end
    end

    // receiver: random stalls, one long hold on request
    initial begin
        int n;
        chunk_t c;
        forever begin
            n = calm ? 0 : $urandom_range(0, 5);
            if (hold_long) begin
                n = 400;
                hold_long = 0;
            end
            if (n > 0) begin
                m_ready <= 0;
                repeat (n) @(posedge aclk);
            end
            m_ready <= 1;
            do @(posedge aclk); while (!m_valid);
            c.data = {m_chunk_word7, m_chunk_word6, m_chunk_word5, m_chunk_word4,
                      m_chunk_word3, m_chunk_word2, m_chunk_word1, m_chunk_word0};
            c.n = m_byte_count; c.last = m_last_chunk; c.st = m_status;
            sb.check_chunk(c);
        end
    end

    task send_word(input bit [7:0] b, input bit eoi);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_valid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1;
        s_in_byte <= b;
        s_end_of_input <= eoi;
        do @(posedge aclk); while (!s_ready);
        sb.note_word(b, eoi);
    endtask

    // append one code at the current width, send every whole byte
    task put_code(input int code);
        enc_bits = (enc_bits << enc_w) | code;
        enc_n += enc_w;
        if (code == CODE_CLEAR) begin
            enc_nf = 258; enc_w = 9; enc_first = 1;
        end else if (code != CODE_EOD) begin
            if (enc_first) begin
                enc_first = 0;
            end else begin
                enc_nf++;
                if (enc_w < 12 && enc_nf + enc_early == (1 << enc_w)) enc_w++;
            end
        end
        if (enc_w > max_width) max_width = enc_w;
        while (enc_n >= 8) begin
            send_word(8'((enc_bits >> (enc_n - 8)) & 8'hff), 1'b0);
            enc_n -= 8;
        end
    endtask

    task put_random(input bit allow_clear);
        int r;
        r = $urandom_range(0, 99);
        if (enc_first || r < 40 || (r < 80 && enc_nf == 258)) put_code($urandom_range(0, 255));
        else if (r < 80) put_code($urandom_range(258, enc_nf - 1));
        else if (r < 97 || !allow_clear) put_code(enc_nf);
        else put_code(CODE_CLEAR);
    endtask

    // pad with clear codes to a byte boundary, then let the block drain
    task settle();
        while (enc_n != 0) put_code(CODE_CLEAR);
        s_valid <= 0;
        while (sb.chunks_due.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    task set_early(input bit v);
        cfg_wr_en <= 1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 0;
        sb.early = v;
        enc_early = v;
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        set_early(1);

        // directed: literal extremes, table hit, KwKwK, clear, KwKwK right after clear
        put_code(0); put_code(255); put_code(259); put_code(258);
        put_code(CODE_CLEAR); put_code(65); put_code(258); put_code(256 + 2);
        put_code(CODE_CLEAR);
        settle();

        repeat (55) put_random(1);
        settle();

        // early change off, no clears, long receiver hold midway
        set_early(0);
        repeat (45) put_random(0);
        hold_long = 1;
        repeat (30) put_random(0);
        settle();

        // back to early change with no idling on either side
        set_early(1);
        calm = 1;
        repeat (40) put_random(1);
        settle();
        calm = 0;

        ending = finish_kind_t'($urandom_range(0, 4));
        case (ending)
            END_EOD: begin
                put_code($urandom_range(0, 255));
                put_code(CODE_EOD);
            end
            END_BAD_CODE: begin
                put_code($urandom_range(0, 255));
                put_code($urandom_range(259, 511));
            end
            END_FIRST_TABLE: put_code($urandom_range(258, 511));
            END_TRUNC: ;
            END_FLAG_OK: put_code($urandom_range(0, 255));
            default: ;
        endcase
        // final word carries the end flag; after a stream end it is simply ignored
        send_word(8'((enc_bits << (8 - enc_n)) & 8'hff), 1'b1);
        s_valid <= 0;
        while (sb.chunks_due.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);

        $display("covered %0d stream words, %0d chunks, code width up to %0d bits,",
                 sb.words_seen, sb.chunks_seen, max_width);
        $display("both early-change settings and stream ending %s", ending.name());
        if (sb.errors == 0 && sb.chunks_due.size() == 0) begin
            $display("lzw_stream_decoder_unit_tb: done, clean");
        end else begin
            $display("%0d mismatches, %0d chunks never seen", sb.errors, sb.chunks_due.size());
            $display("lzw_stream_decoder_unit_tb: done, errors");
        end
        $finish;
    end
endmodule

### files.f
hdl/lzwd_pkg.sv
hdl/lzwd_dict_ram.sv
hdl/lzwd_stage_ram.sv
hdl/lzw_stream_decoder_unit.sv
test/lzw_stream_decoder_unit_tb.sv
